@@ rtl/elsr_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the LOOK request scheduler.
`timescale 1ns / 1ps

package elsr_pkg;

  // Floor numbers are six bits wide; the request bitmap has one bit per floor code.
  localparam int FLOOR_W   = 6;
  localparam int MAP_DEPTH = 64;
  localparam int FLOOR_IN_W = 7;
  localparam int STATUS_W  = 3;

  // Highest floor that the car serves.
  localparam int TOP_FLOOR = 63;

  // Start floor after reset.
  localparam logic [FLOOR_W-1:0] START_RESET = 6'd32;

  // Operation codes of an input item.
  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  // Status codes of a result item.
  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_START     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STOP      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_in;      // capture the input payload
    logic do_add;       // apply an add and load its status result
    logic load_first;   // prepare a schedule: pending stop is the first request
    logic step;         // move the scan pointer within the current run
    logic switch_run;   // start the second run
    logic emit_pend;    // send the pending stop, not the final one
    logic emit_last;    // send the pending stop as the final result
    logic emit_empty;   // send the empty-schedule result
    logic clear_store;  // forget all requests
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;     // output register can take a result this cycle
    logic have_first;   // at least one request is stored
    logic hit;          // floor under the scan pointer is a stop of this run
    logic run_end;      // scan pointer is on the last floor of this run
    logic phase;        // 0 during the first run, 1 during the second
  } sts_t;

endpackage

@@ rtl/elsr_ctrl.sv @@
// Controller state machine of the LOOK request scheduler.
`timescale 1ns / 1ps

module elsr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            op,
  input  elsr_pkg::sts_t  sts,
  output logic            in_stall,
  output logic            cfg_ready,
  output elsr_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ADD   = 3'd1;
  localparam logic [2:0] S_FIRST = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // Input and configuration are taken only between items.
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_in = 1'b1;
          if (op == elsr_pkg::OP_ADD) begin
            state_next = S_ADD;
          end else if (sts.have_first) begin
            state_next = S_FIRST;
          end else begin
            state_next = S_EMPTY;
          end
        end
      end
      S_ADD: begin
        if (sts.out_free) begin
          cmd.do_add = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIRST: begin
        cmd.load_first = 1'b1;
        state_next     = S_SCAN;
      end
      S_SCAN: begin
        // A stop found while the output is still full waits where it is.
        if (!(sts.hit && !sts.out_free)) begin
          cmd.emit_pend = sts.hit;
          if (sts.run_end) begin
            if (!sts.phase) begin
              cmd.switch_run = 1'b1;
            end else begin
              state_next = S_FLUSH;
            end
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.emit_last   = 1'b1;
          cmd.clear_store = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit_empty = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTHESIS
  // A scan step never passes over a stop that has not been sent.
  a_no_skip: assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.switch_run) && sts.hit |-> cmd.emit_pend)
    else $error("scan moved past an unsent stop");

  // The final stop of a schedule is always followed by an idle controller.
  a_flush_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_last |=> !in_stall)
    else $error("controller not idle after the final stop");

  // The empty result is only sent when nothing is stored.
  a_empty_only: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_empty |-> !sts.have_first)
    else $error("empty result with requests stored");
`endif

endmodule

@@ rtl/elsr_datapath.sv @@
// Datapath of the LOOK request scheduler: request bitmap, scan pointer and output register.
`timescale 1ns / 1ps

module elsr_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [elsr_pkg::FLOOR_W-1:0]          cfg_data,
  input  logic [elsr_pkg::FLOOR_IN_W-1:0]       floor,
  input  elsr_pkg::cmd_t                        cmd,
  input  logic                                  out_stall,
  output elsr_pkg::sts_t                        sts,
  output logic                                  out_valid,
  output logic [elsr_pkg::FLOOR_W-1:0]          stop_floor,
  output logic [elsr_pkg::STATUS_W-1:0]         status,
  output logic                                  last
);

  localparam logic [elsr_pkg::FLOOR_W-1:0] TOP =
    elsr_pkg::FLOOR_W'(elsr_pkg::TOP_FLOOR);
  localparam logic [elsr_pkg::FLOOR_W-1:0] ONE = elsr_pkg::FLOOR_W'(1);

  logic [elsr_pkg::FLOOR_W-1:0]    start_floor;
  logic [elsr_pkg::FLOOR_IN_W-1:0] in_floor;
  logic [elsr_pkg::MAP_DEPTH-1:0]  req_map;
  logic [elsr_pkg::FLOOR_W-1:0]    first_request;
  logic                            have_first;
  logic [elsr_pkg::FLOOR_W-1:0]    ptr;
  logic                            phase;
  logic [elsr_pkg::FLOOR_W-1:0]    pend_floor;

  logic [elsr_pkg::FLOOR_W-1:0]    add_idx;
  logic                            add_range;
  logic [elsr_pkg::STATUS_W-1:0]   add_status;
  logic [elsr_pkg::FLOOR_W-1:0]    add_stop;
  logic                            up_first;
  logic                            dir_up;
  logic                            in_run;
  logic                            out_free;
  logic                            out_load;

  // Start floor register.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_floor <= elsr_pkg::START_RESET;
    end else if (cfg_we) begin
      start_floor <= cfg_data;
    end
  end

  // Input payload capture.
  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      in_floor <= floor;
    end
  end

  // Classification of an add: range first, then start floor, then duplicate.
  assign add_idx   = in_floor[elsr_pkg::FLOOR_W-1:0];
  assign add_range = (in_floor == '0) ||
                     (in_floor > elsr_pkg::FLOOR_IN_W'(elsr_pkg::TOP_FLOOR));
  assign add_stop  = add_range ? '0 : add_idx;

  always_comb begin
    if (add_range) begin
      add_status = elsr_pkg::ST_RANGE;
    end else if (add_idx == start_floor) begin
      add_status = elsr_pkg::ST_START;
    end else if (req_map[add_idx]) begin
      add_status = elsr_pkg::ST_DUPLICATE;
    end else begin
      add_status = elsr_pkg::ST_ACCEPTED;
    end
  end

  // Request store; a finished schedule empties it.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear_store) begin
      req_map       <= '0;
      have_first    <= 1'b0;
      first_request <= '0;
    end else if (cmd.do_add && (add_status == elsr_pkg::ST_ACCEPTED)) begin
      req_map[add_idx] <= 1'b1;
      if (!have_first) begin
        have_first    <= 1'b1;
        first_request <= add_idx;
      end
    end
  end

  // Run direction: the first run goes towards the first request.
  assign up_first = (first_request > start_floor);
  assign dir_up   = up_first ^ phase;
  assign in_run   = dir_up ? (ptr > start_floor) : (ptr < start_floor);

  // Scan pointer, run phase and pending stop.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (cmd.load_first) begin
      phase <= 1'b0;
    end else if (cmd.switch_run) begin
      phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_first) begin
      ptr        <= up_first ? ONE : TOP;
      pend_floor <= first_request;
    end else begin
      if (cmd.switch_run) begin
        ptr <= up_first ? TOP : ONE;
      end else if (cmd.step) begin
        ptr <= dir_up ? (ptr + ONE) : (ptr - ONE);
      end
      if (cmd.emit_pend) begin
        pend_floor <= ptr;
      end
    end
  end

  // Output register; it frees itself when the receiver takes the transfer.
  assign out_free = !out_valid || !out_stall;
  assign out_load = cmd.do_add || cmd.emit_pend || cmd.emit_last || cmd.emit_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_add) begin
      stop_floor <= add_stop;
      status     <= add_status;
      last       <= 1'b1;
    end else if (cmd.emit_pend || cmd.emit_last) begin
      stop_floor <= pend_floor;
      status     <= elsr_pkg::ST_STOP;
      last       <= cmd.emit_last;
    end else if (cmd.emit_empty) begin
      stop_floor <= '0;
      status     <= elsr_pkg::ST_EMPTY;
      last       <= 1'b1;
    end
  end

  // Status to the controller.
  assign sts.out_free   = out_free;
  assign sts.have_first = have_first;
  assign sts.hit        = req_map[ptr] && in_run && (ptr != first_request);
  assign sts.run_end    = dir_up ? (ptr == TOP) : (ptr == ONE);
  assign sts.phase      = phase;

`ifndef SYNTHESIS
  // Floor zero is never stored.
  a_no_floor_zero: assert property (@(posedge clk) disable iff (rst)
    !req_map[0])
    else $error("floor zero stored");

  // The first request is known exactly when the store holds something.
  a_first_map: assert property (@(posedge clk) disable iff (rst)
    have_first == (|req_map))
    else $error("first request flag disagrees with the bitmap");

  // A result is only loaded into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result loaded over an untaken transfer");

  // At most one source loads the output register.
  a_one_source: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.do_add, cmd.emit_pend, cmd.emit_last, cmd.emit_empty}))
    else $error("several result sources in one cycle");
`endif

endmodule

@@ rtl/elevator_look_request_scheduler.sv @@
// Top level of the LOOK request scheduler: controller and datapath.
`timescale 1ns / 1ps

// Usage. The car waits at start_floor, written through cfg_valid/cfg_ready/cfg_data
// (reset value 32); write it only while the block is idle. Input transfers carry op and
// floor. An add captures the floor and then, once the output register is free, loads its
// one result (status accepted, duplicate, out of range or start floor) into the output
// register and returns to idle, where the next item can be taken. A finish answers the
// first accepted request, then the stored floors of the run on its side of the start
// floor, then the run on the other side; the final result carries last. With nothing
// stored it answers one empty result. A finish scans the request bitmap one floor per
// cycle over both runs, pausing at a stop while the output is full; no new item is
// taken until the scan ends.
// One result is held in the output register and one stop waits in the datapath, so
// while the receiver holds out_stall the scan pauses at the next stop and nothing is
// lost. in_stall is high while an item is in progress. Reset clears the store and the
// output, and the block is ready in the next cycle. The store is also cleared at the
// end of every finish.
module elevator_look_request_scheduler (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [elsr_pkg::FLOOR_W-1:0]          cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  op,
  input  logic [elsr_pkg::FLOOR_IN_W-1:0]       floor,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [elsr_pkg::FLOOR_W-1:0]          stop_floor,
  output logic [elsr_pkg::STATUS_W-1:0]         status,
  output logic                                  last
);

  elsr_pkg::cmd_t cmd;
  elsr_pkg::sts_t sts;
  logic           cfg_we;

  // Configuration write completes on the valid/ready transfer.
  assign cfg_we = cfg_valid && cfg_ready;

  // Sequencing of adds and schedule scans.
  elsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .op        (op),
    .sts       (sts),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // Request store, scan and result register.
  elsr_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .floor      (floor),
    .cmd        (cmd),
    .out_stall  (out_stall),
    .sts        (sts),
    .out_valid  (out_valid),
    .stop_floor (stop_floor),
    .status     (status),
    .last       (last)
  );

endmodule
